// File: sv/lpp_pkg.sv
`timescale 1ns / 1ps
// Shared constants, register indexes and types for the lidar point pinhole projection block.
// No dependencies; every other file refers to this package by scoped names.
package lpp_pkg;

	// Field widths of the stream words and registers.
	localparam int COORD_W    = 24;
	localparam int COEF_W     = 16;
	localparam int ROT_FRAC   = 14;
	localparam int TRANS_W    = 20;
	localparam int PIX_W      = 16;
	localparam int INT_W      = 8;
	localparam int DEPTH_W    = 23;

	// Arithmetic widths, all derived from the field widths above.
	localparam int PROD_W     = COORD_W + COEF_W;     // one rotation product
	localparam int ACC_W      = PROD_W + 2;           // sum of three products and offset
	localparam int CAM_W      = ACC_W - ROT_FRAC;     // camera-frame coordinate, signed
	localparam int MULA_W     = PIX_W + 1;            // multiplier port A, signed
	localparam int MUL_W      = MULA_W + CAM_W;       // multiplier product, signed
	localparam int NUM_W      = PIX_W + CAM_W;        // dividend magnitude
	localparam int DEN_W      = CAM_W - 1;            // divisor, positive depth
	localparam int QUO_W      = PIX_W;                // quotient bits kept
	localparam int DSH_W      = DEN_W + QUO_W;        // shifted divisor
	localparam int CNT_W      = $clog2(QUO_W + 1);
	localparam int UPIX_W     = PIX_W + 2;            // signed pixel before range tests

	// Register geometry.
	localparam int ROW_W      = 3 * COEF_W;
	localparam int TRANS_REG_W = 3 * TRANS_W;
	localparam int PAIR_W     = 2 * PIX_W;
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = TRANS_REG_W;

	localparam logic [CFG_ADDR_W-1:0] CFG_ROW0  = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] CFG_ROW1  = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] CFG_ROW2  = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] CFG_TRANS = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] CFG_FOCAL = 3'd4;
	localparam logic [CFG_ADDR_W-1:0] CFG_PP    = 3'd5;

	// Stream word geometry.
	localparam int S_BITS     = 3 * COORD_W + INT_W;
	localparam int S_DATA_W   = ((S_BITS + 7) / 8) * 8;
	localparam int S_USER_W   = 2;
	localparam int TU_MISSING = 0;
	localparam int TU_FRAME_START = 1;
	localparam int OUT_BITS   = 2 * PIX_W + 3 * DEPTH_W + 3 * INT_W;
	localparam int M_DATA_W   = ((OUT_BITS + 7) / 8) * 8;

	localparam logic [DEPTH_W-1:0] DEPTH_MAX = {DEPTH_W{1'b1}};
	localparam logic [INT_W-1:0]   INT_MAX   = {INT_W{1'b1}};

	// Decoded configuration. Indexes run row, then column (x, y, z).
	typedef struct packed {
		logic [2:0][2:0][COEF_W-1:0] coef;
		logic [2:0][TRANS_W-1:0]     trans;
		logic [PIX_W-1:0]            fx;
		logic [PIX_W-1:0]            fy;
		logic [PIX_W-1:0]            cx;
		logic [PIX_W-1:0]            cy;
	} cfg_t;

	// Controls of the shared multiply-accumulate unit.
	typedef struct packed {
		logic mul_en;
		logic acc_en;
		logic acc_load;
	} mac_ctl_t;

	// Divider status and result.
	typedef struct packed {
		logic             done;
		logic             ovf;
		logic             rem_nz;
		logic [QUO_W-1:0] quo;
	} div_res_t;

	// Running extremes of the frame.
	typedef struct packed {
		logic [DEPTH_W-1:0] min_depth;
		logic [DEPTH_W-1:0] max_depth;
		logic [INT_W-1:0]   min_int;
		logic [INT_W-1:0]   max_int;
	} stats_t;

endpackage

// File: sv/lpp_cfg.sv
`timescale 1ns / 1ps
// Configuration register file: rotation rows, translation, focal lengths, principal point.
// Depends on lpp_pkg.
module lpp_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [lpp_pkg::CFG_ADDR_W-1:0]    cfg_addr,
	input  logic [lpp_pkg::CFG_DATA_W-1:0]    cfg_data,
	output lpp_pkg::cfg_t                     cfg
);

	logic [2:0][lpp_pkg::ROW_W-1:0]     row_q;
	logic [lpp_pkg::TRANS_REG_W-1:0]    trans_q;
	logic [lpp_pkg::PAIR_W-1:0]         focal_q;
	logic [lpp_pkg::PAIR_W-1:0]         pp_q;

	// Reset gives the identity matrix and zero for everything else.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q[0] <= {16'h4000, 32'h0};
			row_q[1] <= {16'h0, 16'h4000, 16'h0};
			row_q[2] <= {32'h0, 16'h4000};
			trans_q  <= '0;
			focal_q  <= '0;
			pp_q     <= '0;
		end else if (cfg_we) begin
			case (cfg_addr)
				lpp_pkg::CFG_ROW0:  row_q[0] <= cfg_data[lpp_pkg::ROW_W-1:0];
				lpp_pkg::CFG_ROW1:  row_q[1] <= cfg_data[lpp_pkg::ROW_W-1:0];
				lpp_pkg::CFG_ROW2:  row_q[2] <= cfg_data[lpp_pkg::ROW_W-1:0];
				lpp_pkg::CFG_TRANS: trans_q  <= cfg_data[lpp_pkg::TRANS_REG_W-1:0];
				lpp_pkg::CFG_FOCAL: focal_q  <= cfg_data[lpp_pkg::PAIR_W-1:0];
				lpp_pkg::CFG_PP:    pp_q     <= cfg_data[lpp_pkg::PAIR_W-1:0];
				default: ;
			endcase
		end
	end

	// Within a row the x coefficient sits in the top slice; likewise the x offset.
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				cfg.coef[r][c] = row_q[r][(2 - c) * lpp_pkg::COEF_W +: lpp_pkg::COEF_W];
			end
			cfg.trans[r] = trans_q[(2 - r) * lpp_pkg::TRANS_W +: lpp_pkg::TRANS_W];
		end
		cfg.fx = focal_q[lpp_pkg::PAIR_W-1:lpp_pkg::PIX_W];
		cfg.fy = focal_q[lpp_pkg::PIX_W-1:0];
		cfg.cx = pp_q[lpp_pkg::PAIR_W-1:lpp_pkg::PIX_W];
		cfg.cy = pp_q[lpp_pkg::PIX_W-1:0];
	end

endmodule

// File: sv/lpp_mac.sv
`timescale 1ns / 1ps
// Shared signed multiplier with a registered product and a following accumulator.
// Depends on lpp_pkg.
module lpp_mac (
	input  logic                                clk,
	input  lpp_pkg::mac_ctl_t                   ctl,
	input  logic signed [lpp_pkg::MULA_W-1:0]   mul_a,
	input  logic signed [lpp_pkg::CAM_W-1:0]    mul_b,
	input  logic signed [lpp_pkg::ACC_W-1:0]    preload,
	output logic signed [lpp_pkg::MUL_W-1:0]    prod,
	output logic signed [lpp_pkg::ACC_W-1:0]    acc
);

	logic signed [lpp_pkg::MUL_W-1:0] prod_q;
	logic signed [lpp_pkg::ACC_W-1:0] acc_q;
	logic signed [lpp_pkg::ACC_W-1:0] acc_base;

	// The accumulator adds the product registered in the previous cycle.
	assign acc_base = ctl.acc_load ? preload : acc_q;

	always_ff @(posedge clk) begin
		if (ctl.mul_en) begin
			prod_q <= mul_a * mul_b;
		end
		if (ctl.acc_en) begin
			acc_q <= acc_base + $signed(prod_q[lpp_pkg::ACC_W-1:0]);
		end
	end

	assign prod = prod_q;
	assign acc  = acc_q;

endmodule

// File: sv/lpp_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, with an up-front quotient overflow check.
// Depends on lpp_pkg.
module lpp_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [lpp_pkg::NUM_W-1:0]         num,
	input  logic [lpp_pkg::DEN_W-1:0]         den,
	output lpp_pkg::div_res_t                 res
);

	logic                         busy_q;
	logic                         chk_q;
	logic                         done_q;
	logic [lpp_pkg::CNT_W-1:0]    cnt_q;
	logic [lpp_pkg::NUM_W-1:0]    rem_q;
	logic [lpp_pkg::DSH_W-1:0]    dsh_q;
	logic [lpp_pkg::QUO_W-1:0]    quo_q;
	logic                         ovf_q;
	logic                         ge;
	logic [lpp_pkg::NUM_W-1:0]    diff;

	assign ge   = rem_q >= {1'b0, dsh_q};
	assign diff = rem_q - {1'b0, dsh_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			chk_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				chk_q  <= 1'b1;
				cnt_q  <= lpp_pkg::CNT_W'(lpp_pkg::QUO_W);
			end else if (busy_q) begin
				if (chk_q) begin
					chk_q <= 1'b0;
					if (ge) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end
				end else begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == lpp_pkg::CNT_W'(1)) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			dsh_q <= {den, {lpp_pkg::QUO_W{1'b0}}};
			quo_q <= '0;
			ovf_q <= 1'b0;
		end else if (busy_q) begin
			dsh_q <= dsh_q >> 1;
			if (chk_q) begin
				ovf_q <= ge;
			end else begin
				quo_q <= {quo_q[lpp_pkg::QUO_W-2:0], ge};
				if (ge) begin
					rem_q <= diff;
				end
			end
		end
	end

	assign res.done   = done_q;
	assign res.ovf    = ovf_q;
	assign res.rem_nz = |rem_q;
	assign res.quo    = quo_q;

	// Once past the overflow check the partial remainder stays below twice the divisor step.
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !chk_q) |-> (rem_q < {1'b0, dsh_q, 1'b0}))
		else $error("divider remainder out of range");

endmodule

// File: sv/lpp_stats.sv
`timescale 1ns / 1ps
// Running minimum and maximum of depth and intensity over the emitted points of a frame.
// Depends on lpp_pkg.
module lpp_stats (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           clear,
	input  logic                           upd,
	input  logic [lpp_pkg::DEPTH_W-1:0]    depth,
	input  logic [lpp_pkg::INT_W-1:0]      inten,
	output lpp_pkg::stats_t                nxt
);

	lpp_pkg::stats_t cur_q;

	// Extremes with the current point taken in.
	always_comb begin
		nxt.min_depth = (depth < cur_q.min_depth) ? depth : cur_q.min_depth;
		nxt.max_depth = (depth > cur_q.max_depth) ? depth : cur_q.max_depth;
		nxt.min_int   = (inten < cur_q.min_int) ? inten : cur_q.min_int;
		nxt.max_int   = (inten > cur_q.max_int) ? inten : cur_q.max_int;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q.min_depth <= lpp_pkg::DEPTH_MAX;
			cur_q.max_depth <= '0;
			cur_q.min_int   <= lpp_pkg::INT_MAX;
			cur_q.max_int   <= '0;
		end else if (clear) begin
			cur_q.min_depth <= lpp_pkg::DEPTH_MAX;
			cur_q.max_depth <= '0;
			cur_q.min_int   <= lpp_pkg::INT_MAX;
			cur_q.max_int   <= '0;
		end else if (upd) begin
			cur_q <= nxt;
		end
	end

	// After a point has been counted the extremes are ordered.
	a_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		upd |=> (cur_q.min_depth <= cur_q.max_depth && cur_q.min_int <= cur_q.max_int))
		else $error("running extremes out of order");

endmodule

// File: sv/lidar_point_pinhole_projection.sv
`timescale 1ns / 1ps
// Lidar point to pinhole camera projection: a sequencer driving one shared multiply-accumulate
// unit and one shared bit-serial divider. Depends on lpp_pkg, lpp_cfg, lpp_mac, lpp_div, lpp_stats.
// Sequence: an accepted point runs the rotation and numerator products on the shared multiplier,
// then two divisions (u, v) on the shared divider, each followed by a pixel range test, then an
// output state that waits while the output register holds a word not yet taken. A point behind
// the camera frees the block after the rotation, a missing point at once; a new point is taken
// only after the last is through, as s_axis_tready is high only while the sequencer is idle.
// Reset (arst_n low, asynchronous) loads the identity rotation, zero for the other registers,
// clears the running extremes and empties the output register.
module lidar_point_pinhole_projection (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// s_axis_tdata, low to high: point_x[23:0], point_y[47:24], point_z[71:48],
	// point_intensity[79:72]
	input  logic [lpp_pkg::S_DATA_W-1:0]      s_axis_tdata,
	// s_axis_tuser, low to high: point_missing[0], frame_start[1]
	input  logic [lpp_pkg::S_USER_W-1:0]      s_axis_tuser,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// m_axis_tdata, low to high: pixel_u[15:0], pixel_v[31:16], depth[54:32],
	// out_intensity[62:55], min_depth[85:63], max_depth[108:86], min_intensity[116:109],
	// max_intensity[124:117], zero fill [127:125]
	output logic [lpp_pkg::M_DATA_W-1:0]      m_axis_tdata,
	input  logic                              cfg_we,
	input  logic [lpp_pkg::CFG_ADDR_W-1:0]    cfg_addr,
	input  logic [lpp_pkg::CFG_DATA_W-1:0]    cfg_data
);

	// Sequencer states.
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_ROT  = 3'd1;
	localparam logic [2:0] ST_DIVX = 3'd2;
	localparam logic [2:0] ST_PIXX = 3'd3;
	localparam logic [2:0] ST_DIVY = 3'd4;
	localparam logic [2:0] ST_PIXY = 3'd5;
	localparam logic [2:0] ST_EMIT = 3'd6;

	// Milestones of the rotation phase. Steps 0 to 8 issue the nine rotation products; each
	// product is accumulated one step later, and a finished row is read out one step after that.
	localparam logic [3:0] STEP_FX       = 4'd9;
	localparam logic [3:0] STEP_FY       = 4'd10;
	localparam logic [3:0] STEP_ACC_LAST = 4'd9;
	localparam logic [3:0] STEP_XC       = 4'd4;
	localparam logic [3:0] STEP_YC       = 4'd7;
	localparam logic [3:0] STEP_ZC       = 4'd10;
	localparam logic [3:0] STEP_LAST     = 4'd11;

	lpp_pkg::cfg_t                          cfg;
	lpp_pkg::mac_ctl_t                      mac_ctl;
	lpp_pkg::div_res_t                      div_res;
	lpp_pkg::stats_t                        stats_nxt;

	logic [2:0]                             state_q;
	logic [3:0]                             step_q;
	logic [2:0][lpp_pkg::COORD_W-1:0]       pt_q;
	logic [lpp_pkg::INT_W-1:0]              int_q;
	logic signed [lpp_pkg::CAM_W-1:0]       xc_q;
	logic signed [lpp_pkg::CAM_W-1:0]       yc_q;
	logic signed [lpp_pkg::CAM_W-1:0]       zc_q;
	logic [lpp_pkg::NUM_W-1:0]              numx_q;
	logic [lpp_pkg::NUM_W-1:0]              numy_q;
	logic                                   negx_q;
	logic                                   negy_q;
	logic [lpp_pkg::PIX_W-1:0]              u_q;
	logic [lpp_pkg::PIX_W-1:0]              v_q;
	logic                                   m_valid_q;
	logic [lpp_pkg::M_DATA_W-1:0]           m_data_q;

	logic                                   s_fire;
	logic                                   emit_fire;
	logic                                   zc_pos;
	logic [1:0]                             row_sel;
	logic [1:0]                             col_sel;
	logic signed [lpp_pkg::MULA_W-1:0]      mul_a;
	logic signed [lpp_pkg::CAM_W-1:0]       mul_b;
	logic signed [lpp_pkg::ACC_W-1:0]       preload;
	logic signed [lpp_pkg::MUL_W-1:0]       prod;
	logic signed [lpp_pkg::MUL_W-1:0]       prod_abs;
	logic signed [lpp_pkg::ACC_W-1:0]       acc;
	logic                                   div_start;
	logic [lpp_pkg::NUM_W-1:0]              div_num;
	logic [lpp_pkg::TRANS_W-1:0]            trans_sel;
	logic [lpp_pkg::COEF_W-1:0]             coef_sel;
	logic [lpp_pkg::COORD_W-1:0]            coord_sel;
	logic [lpp_pkg::DEPTH_W-1:0]            depth;

	// Pixel computation shared by the u and v passes.
	logic                                   pneg;
	logic [lpp_pkg::PIX_W-1:0]              pc;
	logic [lpp_pkg::QUO_W:0]                pmag;
	logic signed [lpp_pkg::UPIX_W-1:0]      pq_mag;
	logic signed [lpp_pkg::UPIX_W-1:0]      pq;
	logic signed [lpp_pkg::UPIX_W-1:0]      pu;
	logic signed [lpp_pkg::UPIX_W-1:0]      p2c;
	logic                                   pok;

	lpp_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	assign s_axis_tready = (state_q == ST_IDLE);
	assign s_fire        = s_axis_tvalid && s_axis_tready;
	assign emit_fire     = (state_q == ST_EMIT) && (!m_valid_q || m_axis_tready);
	assign zc_pos        = !zc_q[lpp_pkg::CAM_W-1] && (|zc_q);

	// Row and column of the rotation product issued at this step. At the row-start
	// accumulate steps (1, 4 and 7) the row number also picks the translation.
	always_comb begin
		case (step_q)
			4'd0:    begin row_sel = 2'd0; col_sel = 2'd0; end
			4'd1:    begin row_sel = 2'd0; col_sel = 2'd1; end
			4'd2:    begin row_sel = 2'd0; col_sel = 2'd2; end
			4'd3:    begin row_sel = 2'd1; col_sel = 2'd0; end
			4'd4:    begin row_sel = 2'd1; col_sel = 2'd1; end
			4'd5:    begin row_sel = 2'd1; col_sel = 2'd2; end
			4'd6:    begin row_sel = 2'd2; col_sel = 2'd0; end
			4'd7:    begin row_sel = 2'd2; col_sel = 2'd1; end
			4'd8:    begin row_sel = 2'd2; col_sel = 2'd2; end
			default: begin row_sel = 2'd0; col_sel = 2'd0; end
		endcase
	end

	// Multiplier operands: rotation products, then fx * xc and fy * yc.
	always_comb begin
		coef_sel  = cfg.coef[row_sel][col_sel];
		coord_sel = pt_q[col_sel];
		trans_sel = cfg.trans[row_sel];
		if (step_q == STEP_FX) begin
			mul_a = $signed({1'b0, cfg.fx});
			mul_b = xc_q;
		end else if (step_q == STEP_FY) begin
			mul_a = $signed({1'b0, cfg.fy});
			mul_b = yc_q;
		end else begin
			mul_a = $signed({{(lpp_pkg::MULA_W - lpp_pkg::COEF_W){coef_sel[lpp_pkg::COEF_W-1]}},
				coef_sel});
			mul_b = $signed({{(lpp_pkg::CAM_W - lpp_pkg::COORD_W){coord_sel[lpp_pkg::COORD_W-1]}},
				coord_sel});
		end
		// The translation is scaled up by the coefficient fraction and carries the rounding
		// half, so the row result is simply the top bits of the accumulator.
		preload = $signed({{(lpp_pkg::ACC_W - lpp_pkg::ROT_FRAC - lpp_pkg::TRANS_W)
			{trans_sel[lpp_pkg::TRANS_W-1]}}, trans_sel, 1'b1, {(lpp_pkg::ROT_FRAC - 1){1'b0}}});
		mac_ctl.mul_en   = (state_q == ST_ROT) && (step_q <= STEP_FY);
		mac_ctl.acc_en   = (state_q == ST_ROT) && (step_q != 4'd0) && (step_q <= STEP_ACC_LAST);
		mac_ctl.acc_load = (step_q == 4'd1) || (step_q == 4'd4) || (step_q == 4'd7);
	end

	lpp_mac u_mac (
		.clk     (clk),
		.ctl     (mac_ctl),
		.mul_a   (mul_a),
		.mul_b   (mul_b),
		.preload (preload),
		.prod    (prod),
		.acc     (acc)
	);

	assign prod_abs = prod[lpp_pkg::MUL_W-1] ? -prod : prod;

	// The divider serves u first, started from the last rotation step, then v.
	assign div_start = ((state_q == ST_ROT) && (step_q == STEP_LAST) && zc_pos) ||
		((state_q == ST_PIXX) && pok);
	assign div_num   = (state_q == ST_ROT) ? numx_q : numy_q;

	lpp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (zc_q[lpp_pkg::DEN_W-1:0]),
		.res    (div_res)
	);

	// Floor division of a negative numerator rounds the magnitude up. The pixel must lie
	// strictly inside the window of twice the principal point and fit in sixteen bits.
	always_comb begin
		pneg   = (state_q == ST_PIXX) ? negx_q : negy_q;
		pc     = (state_q == ST_PIXX) ? cfg.cx : cfg.cy;
		pmag   = {1'b0, div_res.quo} + {{lpp_pkg::QUO_W{1'b0}}, pneg & div_res.rem_nz};
		pq_mag = $signed({{(lpp_pkg::UPIX_W - lpp_pkg::QUO_W - 1){1'b0}}, pmag});
		pq     = pneg ? -pq_mag : pq_mag;
		pu     = $signed({{(lpp_pkg::UPIX_W - lpp_pkg::PIX_W){1'b0}}, pc}) + pq;
		p2c    = $signed({{(lpp_pkg::UPIX_W - lpp_pkg::PIX_W - 1){1'b0}}, pc, 1'b0});
		pok    = !div_res.ovf && (pu > 0) && (pu < p2c) &&
			(pu[lpp_pkg::UPIX_W-1:lpp_pkg::PIX_W] == '0);
	end

	// Depth saturates at the top of its field.
	assign depth = (|zc_q[lpp_pkg::CAM_W-2:lpp_pkg::DEPTH_W]) ? lpp_pkg::DEPTH_MAX :
		zc_q[lpp_pkg::DEPTH_W-1:0];

	lpp_stats u_stats (
		.clk    (clk),
		.arst_n (arst_n),
		.clear  (s_fire && s_axis_tuser[lpp_pkg::TU_FRAME_START]),
		.upd    (emit_fire),
		.depth  (depth),
		.inten  (int_q),
		.nxt    (stats_nxt)
	);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					step_q <= '0;
					if (s_fire && !s_axis_tuser[lpp_pkg::TU_MISSING]) begin
						state_q <= ST_ROT;
					end
				end
				ST_ROT: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_LAST) begin
						state_q <= zc_pos ? ST_DIVX : ST_IDLE;
					end
				end
				ST_DIVX: begin
					if (div_res.done) begin
						state_q <= ST_PIXX;
					end
				end
				ST_PIXX: begin
					state_q <= pok ? ST_DIVY : ST_IDLE;
				end
				ST_DIVY: begin
					if (div_res.done) begin
						state_q <= ST_PIXY;
					end
				end
				ST_PIXY: begin
					state_q <= pok ? ST_EMIT : ST_IDLE;
				end
				ST_EMIT: begin
					if (emit_fire) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Working registers of the point in flight.
	always_ff @(posedge clk) begin
		if (s_fire) begin
			pt_q[0] <= s_axis_tdata[lpp_pkg::COORD_W-1:0];
			pt_q[1] <= s_axis_tdata[2*lpp_pkg::COORD_W-1:lpp_pkg::COORD_W];
			pt_q[2] <= s_axis_tdata[3*lpp_pkg::COORD_W-1:2*lpp_pkg::COORD_W];
			int_q   <= s_axis_tdata[lpp_pkg::S_BITS-1:3*lpp_pkg::COORD_W];
		end
		if (state_q == ST_ROT) begin
			if (step_q == STEP_XC) begin
				xc_q <= acc[lpp_pkg::ACC_W-1:lpp_pkg::ROT_FRAC];
			end
			if (step_q == STEP_YC) begin
				yc_q <= acc[lpp_pkg::ACC_W-1:lpp_pkg::ROT_FRAC];
			end
			// The fx * xc product is ready when z is read out, fy * yc one step later.
			if (step_q == STEP_ZC) begin
				zc_q   <= acc[lpp_pkg::ACC_W-1:lpp_pkg::ROT_FRAC];
				numx_q <= prod_abs[lpp_pkg::NUM_W-1:0];
				negx_q <= prod[lpp_pkg::MUL_W-1];
			end
			if (step_q == STEP_LAST) begin
				numy_q <= prod_abs[lpp_pkg::NUM_W-1:0];
				negy_q <= prod[lpp_pkg::MUL_W-1];
			end
		end
		if (state_q == ST_PIXX) begin
			u_q <= pu[lpp_pkg::PIX_W-1:0];
		end
		if (state_q == ST_PIXY) begin
			v_q <= pu[lpp_pkg::PIX_W-1:0];
		end
	end

	// Output register: a finished word waits here while the next point is taken in.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (emit_fire) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			m_data_q <= {{(lpp_pkg::M_DATA_W - lpp_pkg::OUT_BITS){1'b0}},
				stats_nxt.max_int, stats_nxt.min_int, stats_nxt.max_depth, stats_nxt.min_depth,
				int_q, depth, v_q, u_q};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	// A missing point never starts the arithmetic.
	a_missing_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(s_fire && s_axis_tuser[lpp_pkg::TU_MISSING]) |=> (state_q == ST_IDLE))
		else $error("missing point entered the datapath");

	// Only points in front of the camera reach the output stage.
	a_emit_front: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> zc_pos)
		else $error("point at or behind the camera plane about to be emitted");

endmodule
